// ===== rtl/gct_pkg.sv =====
// ----------------------------------------------------------------------------
// gct_pkg
// Shared types, widths, register indexes and tables for the go-to-goal
// controller pipeline.
// ----------------------------------------------------------------------------
package gct_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam int GUARD_BITS    = 8;
  localparam int CW            = 28;
  localparam int ZW            = 20;
  localparam int BW            = ZW - 2;
  localparam int PW            = CW + 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;

  localparam int ST_OFS        = 0;
  localparam int ST_ROT        = 1;
  localparam int ST_CORDIC     = 2;
  localparam int ST_MUL        = CORDIC_STAGES + 2;
  localparam int ST_DIST       = CORDIC_STAGES + 3;
  localparam int ST_OUT        = CORDIC_STAGES + 4;
  localparam int NUM_STAGES    = CORDIC_STAGES + 5;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

  localparam logic [16:0] TOL_RESET     = 17'd20;
  localparam logic [15:0] INV_GAIN_Q16  = 16'd39797;
  localparam logic [ZW-1:0] HALF_PI_Q16 = ZW'(102944);

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } in_item_t;

  typedef struct packed {
    logic        [16:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic               goal_reached;
  } out_item_t;

  function automatic zw_t atan_q16(input int unsigned idx);
    zw_t a;
    case (idx)
      0:       a = ZW'(51472);
      1:       a = ZW'(30386);
      2:       a = ZW'(16055);
      3:       a = ZW'(8150);
      4:       a = ZW'(4091);
      5:       a = ZW'(2047);
      6:       a = ZW'(1024);
      7:       a = ZW'(512);
      8:       a = ZW'(256);
      9:       a = ZW'(128);
      10:      a = ZW'(64);
      11:      a = ZW'(32);
      12:      a = ZW'(16);
      13:      a = ZW'(8);
      14:      a = ZW'(4);
      15:      a = ZW'(2);
      16:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/gct_cordic.sv =====
// ----------------------------------------------------------------------------
// gct_cordic
// Vectoring CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module gct_cordic
  import gct_pkg::*;
(
  input  logic                     clk,
  input  logic [CORDIC_STAGES-1:0] en,
  input  cw_t                      x_in,
  input  cw_t                      y_in,
  input  zw_t                      z_in,
  output cw_t                      x_out,
  output zw_t                      z_out
);

  cw_t x_r [CORDIC_STAGES];
  cw_t y_r [CORDIC_STAGES];
  zw_t z_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cw_t xp;
    cw_t yp;
    zw_t zp;
    cw_t xs;
    cw_t ys;
    zw_t a;

    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = z_in;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign xs = xp >>> i;
    assign ys = yp >>> i;
    assign a  = atan_q16(i);

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!yp[CW-1]) begin
          x_r[i] <= xp + ys;
          y_r[i] <= yp - xs;
          z_r[i] <= zp + a;
        end else begin
          x_r[i] <= xp - ys;
          y_r[i] <= yp + xs;
          z_r[i] <= zp - a;
        end
      end
    end
  end

  assign x_out = x_r[CORDIC_STAGES-1];
  assign z_out = z_r[CORDIC_STAGES-1];

endmodule

// ===== rtl/go_to_goal_controller_top.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_controller_top
// Proportional go-to-goal drive controller on a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one pose sample per
//   transfer. Output channel out_valid/out_stall/out_data carries one drive
//   command per sample, in order.
//   cfg_we/cfg_index/cfg_wdata write goal_x (0), goal_y (1), tolerance (2);
//   other indexes are ignored. Write only while no sample is in flight.
// Stages: NUM_STAGES register stages (CORDIC_STAGES + 5) from the input
//   transfer to out_valid: offset, quadrant pre-rotation, one stage per
//   micro-rotation, gain multiply, rounding and saturation, tolerance
//   compare in the output register; every stage is one register deep.
// Throughput: one sample per cycle while out_stall does not hold the output.
// Reset: synchronous; all stage valid bits clear, goal returns to (0, 0)
//   and tolerance to 20.
// Stall: each stage holds while the stage after it is full and holding, so
//   empty stages keep filling and input is taken while a result waits until
//   the whole pipeline is full.
// ----------------------------------------------------------------------------
module go_to_goal_controller_top
  import gct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [15:0] goal_x_r;
  logic signed [15:0] goal_y_r;
  logic [16:0]        tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= '0;
      goal_y_r <= '0;
      tol_r    <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:    goal_x_r <= cfg_wdata[15:0];
        REG_GOAL_Y:    goal_y_r <= cfg_wdata[15:0];
        REG_TOLERANCE: tol_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] src_vld;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] ld;

  always_comb begin
    src_vld[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      src_vld[k] = vld_r[k-1];
    end
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld = src_vld & rdy;
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? src_vld[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[ST_OFS];

  logic signed [15:0] hd_r [ST_MUL+1];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      hd_r[0] <= in_data.pose_heading;
    end
    for (int k = 1; k <= ST_MUL; k++) begin
      if (ld[k]) begin
        hd_r[k] <= hd_r[k-1];
      end
    end
  end

  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic signed [16:0] dx_nxt;
  logic signed [16:0] dy_nxt;

  assign dx_nxt = {goal_x_r[15], goal_x_r} - {in_data.pose_x[15], in_data.pose_x};
  assign dy_nxt = {goal_y_r[15], goal_y_r} - {in_data.pose_y[15], in_data.pose_y};

  always_ff @(posedge clk) begin
    if (ld[ST_OFS]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  cw_t x0;
  cw_t y0;
  cw_t rx_r;
  cw_t ry_r;
  zw_t rz_r;
  cw_t rx_nxt;
  cw_t ry_nxt;
  zw_t rz_nxt;

  assign x0 = {{(CW-17-GUARD_BITS){dx_r[16]}}, dx_r, {GUARD_BITS{1'b0}}};
  assign y0 = {{(CW-17-GUARD_BITS){dy_r[16]}}, dy_r, {GUARD_BITS{1'b0}}};

  always_comb begin
    rx_nxt = x0;
    ry_nxt = y0;
    rz_nxt = '0;
    if (x0[CW-1]) begin
      if (!y0[CW-1]) begin
        rx_nxt = y0;
        ry_nxt = -x0;
        rz_nxt = HALF_PI_Q16;
      end else begin
        rx_nxt = -y0;
        ry_nxt = x0;
        rz_nxt = -HALF_PI_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_ROT]) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      rz_r <= rz_nxt;
    end
  end

  cw_t cx;
  zw_t cz;

  gct_cordic u_cordic (
    .clk   (clk),
    .en    (ld[ST_MUL-1:ST_CORDIC]),
    .x_in  (rx_r),
    .y_in  (ry_r),
    .z_in  (rz_r),
    .x_out (cx),
    .z_out (cz)
  );

  logic [CW-2:0]          xc;
  logic [PW-1:0]          prod_r;
  logic [PW-1:0]          prod_nxt;
  logic signed [ZW:0]     zr;
  logic signed [ZW:0]     zsh;
  logic signed [BW-1:0]   bear_r;

  assign xc       = cx[CW-1] ? '0 : cx[CW-2:0];
  assign prod_nxt = xc * INV_GAIN_Q16;
  assign zr       = {cz[ZW-1], cz} + (ZW+1)'(4);
  assign zsh      = zr >>> 3;

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      prod_r <= prod_nxt;
      bear_r <= zsh[BW-1:0];
    end
  end

  logic [PW:0]            rsum;
  logic [PW-24:0]         dq;
  logic [16:0]            dist_nxt;
  logic signed [BW:0]     adiff;
  logic signed [BW:0]     ahalf;
  logic signed [15:0]     ang_nxt;
  logic [16:0]            dist_r;
  logic signed [15:0]     ang_r;
  logic signed [15:0]     hd_d;

  assign hd_d     = hd_r[ST_MUL];
  assign rsum     = {1'b0, prod_r} + (PW+1)'(1 << 23);
  assign dq       = rsum[PW:24];
  assign dist_nxt = (|dq[PW-24:17]) ? 17'h1FFFF : dq[16:0];
  assign adiff    = {bear_r[BW-1], bear_r} - {{(BW+1-16){hd_d[15]}}, hd_d} + (BW+1)'(1);
  assign ahalf    = adiff >>> 1;

  always_comb begin
    if (ahalf > $signed((BW+1)'(32767))) begin
      ang_nxt = 16'sh7FFF;
    end else if (ahalf < $signed(-(BW+1)'(32768))) begin
      ang_nxt = 16'sh8000;
    end else begin
      ang_nxt = ahalf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_DIST]) begin
      dist_r <= dist_nxt;
      ang_r  <= ang_nxt;
    end
  end

  out_item_t out_r;
  out_item_t out_nxt;

  always_comb begin
    if (dist_r <= tol_r) begin
      out_nxt.linear_speed = '0;
      out_nxt.turn_rate    = '0;
      out_nxt.goal_reached = 1'b1;
    end else begin
      out_nxt.linear_speed = dist_r;
      out_nxt.turn_rate    = ang_r;
      out_nxt.goal_reached = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

endmodule

// ===== rtl/gct_checker.sv =====
// ----------------------------------------------------------------------------
// gct_checker
// Port-level checks on the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
module gct_checker
  import gct_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [16:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we && cfg_index == REG_TOLERANCE) begin
      tol_r <= cfg_wdata[16:0];
    end
  end

  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.goal_reached |->
      out_data.linear_speed == '0 && out_data.turn_rate == '0)
    else $error("reached command with nonzero speed");

  a_not_reached_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.goal_reached |-> out_data.linear_speed > tol_r)
    else $error("moving command within tolerance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transfer changed");

endmodule

bind go_to_goal_controller_top gct_checker u_gct_checker (.*);

// ===== tb/go_to_goal_checker.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_checker
// Watches the pose, command and register ports of the go-to-goal controller.
// Each pose transfer queues the drive command computed from its own copy of
// the goal and tolerance. Each command transfer is compared field by field
// against the oldest queued command. Failures are counted for the testbench.
// ----------------------------------------------------------------------------
module go_to_goal_checker
  import gct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_PI    = 102944;
  localparam longint INV_GAIN   = 39797;
  localparam longint LIN_MAX    = 131071;
  localparam longint ANG_MAX    = 32767;
  localparam longint ANG_MIN    = -32768;
  localparam logic [16:0] TOL_AT_RESET = 17'd20;

  longint arctan_q16 [0:23] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic        [16:0] reach_tol;

  out_item_t queued_commands [$];

  function automatic out_item_t predict_command(in_item_t pose);
    longint    dx, dy, cx, cy, cz, tmp, xs, ys, step_angle;
    longint    range_q, brg, turn;
    out_item_t cmd;
    dx = longint'(goal_x) - longint'($signed(pose.pose_x));
    dy = longint'(goal_y) - longint'($signed(pose.pose_y));
    cx = dx * 256;
    cy = dy * 256;
    cz = 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        tmp = cx; cx = cy; cy = -tmp; cz = HALF_PI;
      end else begin
        tmp = cx; cx = -cy; cy = tmp; cz = -HALF_PI;
      end
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      xs = cx >>> k;
      ys = cy >>> k;
      step_angle = (k < 24) ? arctan_q16[k] : 0;
      if (cy >= 0) begin
        cx = cx + ys; cy = cy - xs; cz = cz + step_angle;
      end else begin
        cx = cx - ys; cy = cy + xs; cz = cz - step_angle;
      end
    end
    if (cx < 0) cx = 0;
    range_q = (cx * INV_GAIN + (longint'(1) << 23)) >>> 24;
    if (range_q > LIN_MAX) range_q = LIN_MAX;
    if (range_q <= longint'(reach_tol)) begin
      cmd.linear_speed = '0;
      cmd.turn_rate    = '0;
      cmd.goal_reached = 1'b1;
    end else begin
      brg  = (cz + 4) >>> 3;
      turn = (brg - longint'($signed(pose.pose_heading)) + 1) >>> 1;
      if (turn > ANG_MAX) turn = ANG_MAX;
      if (turn < ANG_MIN) turn = ANG_MIN;
      cmd.linear_speed = range_q[16:0];
      cmd.turn_rate    = turn[15:0];
      cmd.goal_reached = 1'b0;
    end
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      queued_commands.delete();
      goal_x    = '0;
      goal_y    = '0;
      reach_tol = TOL_AT_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (queued_commands.size() == 0) begin
          $display("%0t unexpected command: lin %0d ang %0d reached %0b", $time,
                   out_data.linear_speed, $signed(out_data.turn_rate),
                   out_data.goal_reached);
          fail_count++;
        end else begin
          want = queued_commands.pop_front();
          if (out_data.linear_speed !== want.linear_speed ||
              out_data.turn_rate !== want.turn_rate ||
              out_data.goal_reached !== want.goal_reached) begin
            $display("%0t mismatch: expected lin %0d ang %0d reached %0b, %s",
                     $time, want.linear_speed, $signed(want.turn_rate),
                     want.goal_reached,
                     $sformatf("got lin %0d ang %0d reached %0b",
                               out_data.linear_speed,
                               $signed(out_data.turn_rate),
                               out_data.goal_reached));
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        queued_commands.push_back(predict_command(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_GOAL_X:    goal_x    = cfg_wdata[15:0];
          REG_GOAL_Y:    goal_y    = cfg_wdata[15:0];
          REG_TOLERANCE: reach_tol = cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
    pending_count = queued_commands.size();
  end

endmodule

// ===== tb/tb_go_to_goal_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_go_to_goal_controller_top
// Drives pose samples and register settings into the go-to-goal controller
// under several idle and stall mixes, including a long output hold-off that
// backs the pipeline up. A checker beside the block predicts and compares
// every command; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_go_to_goal_controller_top;
  import gct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  logic signed [15:0] cur_gx  = '0;
  logic signed [15:0] cur_gy  = '0;
  logic        [16:0] cur_tol = 17'd20;

  always #(CLK_PERIOD / 2) clk = ~clk;

  go_to_goal_controller_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  go_to_goal_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // hold the output for a long stretch on request, else stall at random
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] hd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_data.pose_x       <= px;
    in_data.pose_y       <= py;
    in_data.pose_heading <= hd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending_count != 0) @(negedge clk);
    repeat (NUM_STAGES + 4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] gx, input logic [15:0] gy,
                               input logic [16:0] tol);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GOAL_X;
    cfg_wdata <= {1'($urandom), gx};
    @(negedge clk);
    cfg_index <= REG_GOAL_Y;
    cfg_wdata <= {1'($urandom), gy};
    @(negedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 17'($urandom);
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_gx  = gx;
    cur_gy  = gy;
    cur_tol = tol;
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    int span, sel, ox, oy;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        send_pose(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        span = (sel < 8) ? ((cur_tol > 4000) ? 4000 : int'(cur_tol) + 3) : 2;
        ox   = int'($urandom_range(0, 2 * span)) - span;
        oy   = int'($urandom_range(0, 2 * span)) - span;
        send_pose(16'(int'(cur_gx) + ox), 16'(int'(cur_gy) + oy), 16'($urandom));
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset goal at the origin, tolerance 20
    send_pose(16'sd0, 16'sd0, 16'sd0);
    send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
    send_pose(16'sd32767, 16'sd32767, 16'sd32767);
    send_pose(16'sd32767, -16'sd32768, 16'sd0);
    send_pose(-16'sd32768, 16'sd32767, -16'sd32768);
    send_pose(16'sd20, 16'sd0, 16'sd5);
    send_pose(16'sd21, 16'sd0, 16'sd0);
    send_pose(16'sd0, -16'sd21, 16'sd100);
    send_pose(16'sd14, 16'sd14, 16'sd0);
    send_pose(16'sd1000, 16'sd0, 16'sd32767);
    send_pose(16'sd1000, 16'sd0, -16'sd32768);
    send_pose(16'sd0, -16'sd32768, 16'sd1);
    send_pose(-16'sd32768, 16'sd0, 16'sd0);
    in_valid <= 1'b0;

    apply_setting(16'sd32767, -16'sd32768, 17'd0);
    send_pose(-16'sd32768, 16'sd32767, -16'sd32768);
    send_pose(16'sd32767, -16'sd32768, 16'sd0);
    send_pose(16'sd32767, -16'sd32767, 16'sd0);
    send_pose(-16'sd32768, -16'sd32768, 16'sd32767);
    send_pose(16'sd32767, 16'sd32767, -16'sd32768);
    send_pose(16'sd0, 16'sd0, 16'sd0);
    in_valid <= 1'b0;

    apply_setting(-16'sd32768, 16'sd32767, 17'd131071);
    send_pose(16'sd32767, -16'sd32768, 16'sd0);
    send_pose(-16'sd32768, 16'sd32767, 16'sd32767);
    send_pose(16'sd0, 16'sd0, -16'sd32768);
    in_valid <= 1'b0;

    apply_setting(16'($urandom), 16'($urandom), 17'($urandom_range(0, 2047)));
    run_random(300, 0, 0);
    apply_setting(16'($urandom), 16'($urandom), 17'($urandom_range(0, 4095)));
    run_random(250, 84, 0);
    apply_setting(16'($urandom), 16'($urandom), 17'd0);
    run_random(250, 0, 84);
    apply_setting(16'sd0, 16'sd0, 17'($urandom_range(0, 511)));
    run_random(250, 27, 27);

    // back the pipeline up behind a long output hold-off
    apply_setting(16'($urandom), 16'($urandom), 17'($urandom_range(0, 1023)));
    hold_left = HOLD_CYCLES;
    run_random(150, 0, 0);

    apply_setting(16'($urandom), 16'($urandom), 17'd20);
    run_random(150, 0, 0);

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gct_pkg.sv
rtl/gct_cordic.sv
rtl/go_to_goal_controller_top.sv
rtl/gct_checker.sv
tb/go_to_goal_checker.sv
tb/tb_go_to_goal_controller_top.sv
